// ----- rtl/zhs_pkg.sv -----
`default_nettype none
package zhs_pkg;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  zone_index;
        logic [7:0]  device_type;
        logic [31:0] now_time;
    } item_t;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [7:0] event_zone;
        logic       is_online;
        logic       table_full;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [31:0] short_timeout;
        logic [31:0] long_timeout;
        logic [7:0]  long_zone_limit;
        logic [7:0]  exempt_type;
        logic [31:0] clock_valid_after;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  zone;
        logic [7:0]  dtype;
        logic [31:0] stamp;
        logic        latched;
        logic        live;
    } entry_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_DELETE,
        OP_HEARTBEAT,
        OP_QUERY,
        OP_CHECK,
        OP_REPORT,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  zone;
        logic [7:0]  dtype;
        logic [31:0] now;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_SHIFT,
        ST_MOVE
    } state_t;

    localparam logic [2:0] CMD_ADD       = 3'd0;
    localparam logic [2:0] CMD_DELETE    = 3'd1;
    localparam logic [2:0] CMD_HEARTBEAT = 3'd2;
    localparam logic [2:0] CMD_QUERY     = 3'd3;
    localparam logic [2:0] CMD_CHECK     = 3'd4;
    localparam logic [2:0] CMD_REPORT    = 3'd5;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_OFFLINE = 2'd1;
    localparam logic [1:0] EV_ONLINE  = 2'd2;

    localparam logic [2:0] REG_SHORT_TIMEOUT     = 3'd0;
    localparam logic [2:0] REG_LONG_TIMEOUT      = 3'd1;
    localparam logic [2:0] REG_LONG_ZONE_LIMIT   = 3'd2;
    localparam logic [2:0] REG_EXEMPT_TYPE       = 3'd3;
    localparam logic [2:0] REG_CLOCK_VALID_AFTER = 3'd4;

    localparam logic [31:0] RST_SHORT_TIMEOUT     = 32'd600;
    localparam logic [31:0] RST_LONG_TIMEOUT      = 32'd90000;
    localparam logic [7:0]  RST_LONG_ZONE_LIMIT   = 8'd50;
    localparam logic [7:0]  RST_EXEMPT_TYPE       = 8'h01;
    localparam logic [31:0] RST_CLOCK_VALID_AFTER = 32'd1000;

endpackage
`default_nettype wire

// ----- rtl/zhs_fifo.sv -----
`default_nettype none
module zhs_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  wire  clk,
    input  wire  rst_n,
    input  wire  wr,
    input  T     din,
    output logic full,
    input  wire  rd,
    output T     dout,
    output logic empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T              mem [DEPTH];
    logic [AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign dout  = mem[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_wr)
        begin
            wp_next = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (do_rd)
        begin
            rp_next = (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wp_reg] <= din;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/zhs_front.sv -----
`default_nettype none
module zhs_front (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           push,
    input  zhs_pkg::item_t item,
    output logic          full,
    input  wire           job_pop,
    output zhs_pkg::job_t job,
    output logic          job_empty
);
    import zhs_pkg::*;

    job_t cls;

    // decode the command into an operation for the back end
    always_comb
    begin
        cls.zone  = item.zone_index;
        cls.dtype = item.device_type;
        cls.now   = item.now_time;
        unique case (item.cmd)
            CMD_ADD:       cls.op = OP_ADD;
            CMD_DELETE:    cls.op = OP_DELETE;
            CMD_HEARTBEAT: cls.op = OP_HEARTBEAT;
            CMD_QUERY:     cls.op = OP_QUERY;
            CMD_CHECK:     cls.op = OP_CHECK;
            CMD_REPORT:    cls.op = OP_REPORT;
            default:       cls.op = OP_NONE;
        endcase
    end

    zhs_fifo #(.T(job_t), .DEPTH(2)) u_jobq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (push),
        .din   (cls),
        .full  (full),
        .rd    (job_pop),
        .dout  (job),
        .empty (job_empty)
    );
endmodule
`default_nettype wire

// ----- rtl/zhs_back.sv -----
`default_nettype none
module zhs_back #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire              clk,
    input  wire              rst_n,
    input  zhs_pkg::cfg_t    cfg,
    input  zhs_pkg::job_t    job,
    input  wire              job_empty,
    output logic             job_pop,
    output zhs_pkg::result_t res,
    output logic             res_push,
    input  wire              res_full
);
    import zhs_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    entry_t        mem [TABLE_DEPTH];
    entry_t        rd_reg;
    logic [AW-1:0] raddr, waddr;
    entry_t        wdata;
    logic          we;

    state_t        state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next, count_reg, count_next;
    job_t          job_reg, job_next;

    logic          at_end, match, exempt, cond_a, cond_b;
    logic [32:0]   diff;
    logic [31:0]   limit;
    logic [CW-1:0] idx_inc;

    assign idx_inc = idx_reg + 1'b1;
    assign raddr   = (state_reg == ST_SHIFT) ? idx_inc[AW-1:0] : idx_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    assign at_end = (idx_reg == count_reg);
    assign match  = (rd_reg.zone == job_reg.zone);
    assign exempt = (rd_reg.dtype == cfg.exempt_type);
    assign limit  = (rd_reg.zone < cfg.long_zone_limit) ? cfg.long_timeout : cfg.short_timeout;
    assign diff   = {1'b0, job_reg.now} - {1'b0, rd_reg.stamp};
    // a stamp in the future gives a negative difference and never times out
    assign cond_a = (rd_reg.stamp != '0) && !rd_reg.latched && !diff[32]
                    && (diff[31:0] > limit);
    assign cond_b = rd_reg.latched && !rd_reg.live;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        job_next   = job_reg;
        job_pop    = 1'b0;
        we         = 1'b0;
        waddr      = idx_reg[AW-1:0];
        wdata      = rd_reg;
        res_push   = 1'b0;
        res        = '0;
        res.last   = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop    = 1'b1;
                    job_next   = job;
                    idx_next   = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (at_end || job_reg.op == OP_NONE)
                begin
                    if (!res_full)
                    begin
                        res_push   = 1'b1;
                        state_next = ST_IDLE;
                        if (job_reg.op == OP_ADD)
                        begin
                            if (count_reg == CW'(TABLE_DEPTH))
                            begin
                                res.table_full = 1'b1;
                            end
                            else
                            begin
                                we            = 1'b1;
                                waddr         = count_reg[AW-1:0];
                                wdata.zone    = job_reg.zone;
                                wdata.dtype   = job_reg.dtype;
                                wdata.stamp   = (job_reg.now > cfg.clock_valid_after)
                                                ? job_reg.now : '0;
                                wdata.latched = 1'b0;
                                wdata.live    = 1'b0;
                                count_next    = count_reg + 1'b1;
                                res.event_kind = EV_ONLINE;
                                res.event_zone = job_reg.zone;
                            end
                        end
                    end
                end
                else
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                unique case (job_reg.op)
                    OP_CHECK:
                    begin
                        if (cond_a || cond_b)
                        begin
                            if (!res_full)
                            begin
                                res_push   = 1'b1;
                                state_next = ST_IDLE;
                                if (cond_a)
                                begin
                                    we            = 1'b1;
                                    wdata.stamp   = job_reg.now;
                                    wdata.latched = 1'b1;
                                    wdata.live    = 1'b1;
                                    if (!exempt)
                                    begin
                                        res.event_kind = EV_OFFLINE;
                                        res.event_zone = rd_reg.zone;
                                    end
                                end
                                else if (!exempt)
                                begin
                                    we             = 1'b1;
                                    wdata.latched  = 1'b0;
                                    res.event_kind = EV_ONLINE;
                                    res.event_zone = rd_reg.zone;
                                end
                            end
                        end
                        else
                        begin
                            idx_next   = idx_inc;
                            state_next = ST_READ;
                        end
                    end
                    OP_REPORT:
                    begin
                        if (rd_reg.live && !exempt)
                        begin
                            if (!res_full)
                            begin
                                res_push       = 1'b1;
                                res.event_kind = EV_OFFLINE;
                                res.event_zone = rd_reg.zone;
                                res.last       = 1'b0;
                                idx_next       = idx_inc;
                                state_next     = ST_READ;
                            end
                        end
                        else
                        begin
                            idx_next   = idx_inc;
                            state_next = ST_READ;
                        end
                    end
                    default:
                    begin
                        if (!match)
                        begin
                            idx_next   = idx_inc;
                            state_next = ST_READ;
                        end
                        else if (job_reg.op == OP_DELETE)
                        begin
                            state_next = ST_SHIFT;
                        end
                        else if (!res_full)
                        begin
                            res_push   = 1'b1;
                            state_next = ST_IDLE;
                            if (job_reg.op == OP_HEARTBEAT)
                            begin
                                we          = 1'b1;
                                wdata.stamp = job_reg.now;
                                wdata.live  = 1'b0;
                            end
                            else if (job_reg.op == OP_QUERY)
                            begin
                                res.is_online = !rd_reg.live;
                            end
                        end
                    end
                endcase
            end
            ST_SHIFT:
            begin
                // close the gap one entry at a time
                if (idx_inc >= count_reg)
                begin
                    if (!res_full)
                    begin
                        res_push   = 1'b1;
                        count_next = count_reg - 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_MOVE;
                end
            end
            ST_MOVE:
            begin
                we         = 1'b1;
                idx_next   = idx_inc;
                state_next = ST_SHIFT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end
endmodule
`default_nettype wire

// ----- rtl/zone_heartbeat_supervisor.sv -----
`default_nettype none
// channel   direction  handshake          payload
// item      in         push / full        zhs_pkg::item_t
// result    out        pop / empty        zhs_pkg::result_t
// cfg       in         cfg_we (no wait)   cfg_index, cfg_data
//
// A command walks the table one entry at a time: a registered memory read, then
// an evaluate; delete then moves each later entry down with a shift and a move
// step. Reset clears the entry count, queues, state and configuration
// registers, not the entries. Two-deep queues on both sides let commands queue
// while results wait; the walk stalls when it has a result to push and the
// result queue is full.
module zone_heartbeat_supervisor #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push,
    output logic              full,
    input  zhs_pkg::item_t    item,
    output logic              empty,
    input  wire               pop,
    output zhs_pkg::result_t  result,
    input  wire               cfg_we,
    input  wire [2:0]         cfg_index,
    input  wire [31:0]        cfg_data
);
    import zhs_pkg::*;

    cfg_t    cfg_reg;
    job_t    job;
    logic    job_empty, job_pop, res_push, res_full;
    result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_timeout     <= RST_SHORT_TIMEOUT;
            cfg_reg.long_timeout      <= RST_LONG_TIMEOUT;
            cfg_reg.long_zone_limit   <= RST_LONG_ZONE_LIMIT;
            cfg_reg.exempt_type       <= RST_EXEMPT_TYPE;
            cfg_reg.clock_valid_after <= RST_CLOCK_VALID_AFTER;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SHORT_TIMEOUT:     cfg_reg.short_timeout     <= cfg_data;
                REG_LONG_TIMEOUT:      cfg_reg.long_timeout      <= cfg_data;
                REG_LONG_ZONE_LIMIT:   cfg_reg.long_zone_limit   <= cfg_data[7:0];
                REG_EXEMPT_TYPE:       cfg_reg.exempt_type       <= cfg_data[7:0];
                REG_CLOCK_VALID_AFTER: cfg_reg.clock_valid_after <= cfg_data;
                default:               ;
            endcase
        end
    end

    zhs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .job_pop   (job_pop),
        .job       (job),
        .job_empty (job_empty)
    );

    zhs_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job       (job),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .res       (res),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    zhs_fifo #(.T(result_t), .DEPTH(2)) u_resq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_push),
        .din   (res),
        .full  (res_full),
        .rd    (pop),
        .dout  (result),
        .empty (empty)
    );
endmodule
`default_nettype wire
